### hdl/pidpd_pkg.sv
package pidpd_pkg;

	localparam int FRAC_BITS = 16;

	localparam int IN_W = 16;
	localparam int ERR_W = IN_W + 1;
	localparam int GAIN_W = 24;
	localparam int LIMIT_W = 16;
	localparam int THRESH_W = 17;
	localparam int DRIVE_W = ERR_W + FRAC_BITS;

	localparam int OPND_W = ERR_W + 2;
	localparam int MUL_W = GAIN_W + OPND_W;
	localparam int SUM_W = 48;

	localparam int KI_SCALE = 1000;
	localparam logic [GAIN_W-1:0] KI_MIN =
		GAIN_W'(((64'd1 << FRAC_BITS) + 64'(KI_SCALE) - 64'd1) / 64'(KI_SCALE));

	localparam int DIV_N = 100;
	localparam int DIV_HALF = DIV_N / 2;
	localparam int Y_W = GAIN_W + IN_W - 1;
	localparam int Y_LO_W = 20;
	localparam int Y_HI_W = Y_W - Y_LO_W;
	localparam int DIV_SHIFT = Y_W;
	localparam int RECIP_W = 33;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'(DIV_N));
	localparam int FULL_W = Y_W + RECIP_W;
	localparam int Q_W = FULL_W - DIV_SHIFT;
	localparam int R_W = Y_W + 1;

	localparam int QUEUE_DEPTH = 2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE,
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_OUTPUT_LIMIT,
		REG_INTEGRAL_LIMIT,
		REG_ERROR_CEILING,
		REG_DEAD_ZONE
	} reg_idx_t;

	typedef struct packed {
		logic                     func;
		logic signed [IN_W-1:0]   measured;
		logic signed [IN_W-1:0]   target;
		logic signed [IN_W-1:0]   gyro_rate;
	} item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      gated;
	} result_t;

	typedef struct packed {
		logic                     mode;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       output_limit;
		logic [LIMIT_W-1:0]       integ_limit;
		logic [THRESH_W-1:0]      error_ceiling;
		logic [THRESH_W-1:0]      dead_zone;
	} cfg_t;

	typedef struct packed {
		logic                    func;
		logic                    gated;
		logic signed [ERR_W-1:0] err;
		logic signed [IN_W-1:0]  gyro_rate;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic signed [SUM_W-1:0] widen_mul(input logic signed [MUL_W-1:0] v);
		return {{(SUM_W-MUL_W){v[MUL_W-1]}}, v};
	endfunction

	function automatic logic signed [SUM_W-1:0] widen_acc(input logic signed [DRIVE_W-1:0] v);
		return {{(SUM_W-DRIVE_W){v[DRIVE_W-1]}}, v};
	endfunction

	function automatic logic signed [SUM_W-1:0] clamp_sym(input logic signed [SUM_W-1:0] value,
			input logic [LIMIT_W-1:0] limit);
		logic signed [SUM_W-1:0] hi;
		hi = $signed({{(SUM_W-LIMIT_W-FRAC_BITS){1'b0}}, limit, {FRAC_BITS{1'b0}}});
		if (value > hi) begin
			return hi;
		end else if (value < -hi) begin
			return -hi;
		end
		return value;
	endfunction

endpackage

### hdl/pidpd_front.sv
module pidpd_front
	import pidpd_pkg::*;
(
	input  cfg_t          cfg,
	input  logic          item_valid,
	output logic          item_stall,
	input  item_t         item,
	input  queue_status_t q_status,
	output logic          push,
	output cmd_t          cmd
);

	logic signed [ERR_W-1:0] err;
	logic [ERR_W-1:0]        err_mag;
	logic                    over_ceiling;
	logic                    in_dead_zone;

	assign err = {item.target[IN_W-1], item.target} - {item.measured[IN_W-1], item.measured};
	assign err_mag = err[ERR_W-1] ? (~err + 1'b1) : err;

	assign over_ceiling = (cfg.error_ceiling != '0) && (err_mag > cfg.error_ceiling);
	assign in_dead_zone = (cfg.dead_zone != '0) && (err_mag < cfg.dead_zone);

	assign item_stall = q_status.full;
	assign push = item_valid && !q_status.full;

	always_comb begin
		cmd.func = item.func;
		cmd.gated = !item.func && (over_ceiling || in_dead_zone);
		cmd.err = err;
		cmd.gyro_rate = item.gyro_rate;
	end

endmodule

### hdl/pidpd_queue.sv
module pidpd_queue
	import pidpd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cmd_t          push_cmd,
	input  logic          pop,
	output cmd_t          head,
	output queue_status_t q_status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head = entry_q[rd_ptr_q];
	assign q_status.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

endmodule

### hdl/pidpd_back.sv
module pidpd_back
	import pidpd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  queue_status_t q_status,
	input  cmd_t          cmd,
	output logic          cmd_pop,
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result
);

	localparam int STAGES = 8;

	logic              adv;
	logic [STAGES-1:0] stage_vld_q;
	logic              result_valid_q;
	result_t           result_q;

	logic signed [ERR_W-1:0]   err_prev_q;
	logic signed [ERR_W-1:0]   err_prev2_q;
	logic signed [DRIVE_W-1:0] integ_q;
	logic signed [DRIVE_W-1:0] delta_q;

	logic signed [ERR_W:0]   diff1;
	logic signed [ERR_W+1:0] diff2;

	logic                    func_s1, gated_s1;
	logic signed [ERR_W-1:0] err_s1;
	logic signed [ERR_W:0]   d1_s1;
	logic signed [ERR_W+1:0] d2_s1;
	logic signed [IN_W-1:0]  gyro_s1;

	logic signed [OPND_W-1:0] p_opnd, d_opnd, i_opnd;
	logic signed [MUL_W-1:0]  prop_mul, deriv_mul, kie_mul;

	logic                    func_s2, gated_s2;
	logic signed [MUL_W-1:0] prop_s2, deriv_s2, kie_s2;

	logic [MUL_W-1:0]        deriv_mag;
	logic                    func_s3, gated_s3, neg_s3;
	logic [Y_W-1:0]          y_s3;
	logic signed [MUL_W-1:0] prop_s3, deriv_s3, kie_s3;
	logic signed [SUM_W-1:0] icl_s3;

	logic                            func_s4, gated_s4, neg_s4;
	logic [Y_W-1:0]                  y_s4;
	logic [Y_LO_W+RECIP_W-1:0]       lo_s4;
	logic [Y_HI_W+RECIP_W-1:0]       hi_s4;
	logic signed [MUL_W-1:0]         prop_s4, deriv_s4, kie_s4;
	logic signed [SUM_W-1:0]         icl_s4;

	logic [FULL_W-1:0]       full_prod;
	logic                    func_s5, gated_s5, neg_s5;
	logic [Y_W-1:0]          y_s5;
	logic [Q_W-1:0]          q_est_s5;
	logic signed [MUL_W-1:0] prop_s5, deriv_s5, kie_s5;
	logic signed [SUM_W-1:0] icl_s5;

	logic [R_W-1:0]          times_n, rem;
	logic [Q_W-1:0]          quot;
	logic signed [SUM_W-1:0] quot_s, dterm;
	logic                    func_s6, gated_s6;
	logic signed [MUL_W-1:0] prop_s6, kie_s6;
	logic signed [SUM_W-1:0] icl_s6, dterm_s6;

	logic signed [SUM_W-1:0] pd_sum;
	logic                    func_s7, gated_s7;
	logic signed [MUL_W-1:0] kie_s7;
	logic signed [SUM_W-1:0] icl_s7, pd_s7, inc_s7;

	logic [GAIN_W-1:0]         ki_mag;
	logic                      ki_on;
	logic signed [SUM_W-1:0]   integ_sum, delta_sum, integ_clamp, delta_clamp;
	logic signed [DRIVE_W-1:0] integ_next, delta_next;
	logic                      gated_s8;
	logic signed [SUM_W-1:0]   pd_s8;
	logic signed [DRIVE_W-1:0] integ_s8, delta_s8;

	logic signed [SUM_W-1:0]   drive_sum, drive_clamp;
	logic signed [DRIVE_W-1:0] drive_next;

	assign adv = !result_valid_q || !result_stall;
	assign cmd_pop = adv && !q_status.empty;

	assign diff1 = {cmd.err[ERR_W-1], cmd.err} - {err_prev_q[ERR_W-1], err_prev_q};
	assign diff2 = {{2{cmd.err[ERR_W-1]}}, cmd.err} - {err_prev_q[ERR_W-1], err_prev_q, 1'b0}
		+ {{2{err_prev2_q[ERR_W-1]}}, err_prev2_q};

	always_comb begin
		i_opnd = {{2{err_s1[ERR_W-1]}}, err_s1};
		p_opnd = cfg.mode ? {d1_s1[ERR_W], d1_s1} : i_opnd;
		if (func_s1) begin
			d_opnd = {{(OPND_W-IN_W){gyro_s1[IN_W-1]}}, gyro_s1};
		end else if (cfg.mode) begin
			d_opnd = d2_s1;
		end else begin
			d_opnd = {d1_s1[ERR_W], d1_s1};
		end
	end

	assign prop_mul = $signed(cfg.gain_p) * p_opnd;
	assign deriv_mul = $signed(cfg.gain_d) * d_opnd;
	assign kie_mul = $signed(cfg.gain_i) * i_opnd;

	assign deriv_mag = deriv_s2[MUL_W-1] ? $unsigned(-deriv_s2) : $unsigned(deriv_s2);

	assign full_prod = {hi_s4, {Y_LO_W{1'b0}}} + FULL_W'(lo_s4);

	always_comb begin
		times_n = R_W'(q_est_s5) * R_W'(DIV_N);
		rem = {1'b0, y_s5} - times_n;
		quot = (rem >= R_W'(DIV_N)) ? q_est_s5 + 1'b1 : q_est_s5;
		quot_s = $signed({{(SUM_W-Q_W){1'b0}}, quot});
		if (func_s5) begin
			dterm = neg_s5 ? quot_s : -quot_s;
		end else begin
			dterm = widen_mul(deriv_s5);
		end
	end

	assign pd_sum = widen_mul(prop_s6) + dterm_s6;

	assign ki_mag = cfg.gain_i[GAIN_W-1] ? $unsigned(-cfg.gain_i) : $unsigned(cfg.gain_i);
	assign ki_on = (ki_mag >= KI_MIN);

	always_comb begin
		integ_sum = widen_acc(integ_q) + widen_mul(kie_s7);
		delta_sum = widen_acc(delta_q) + inc_s7;
		integ_clamp = clamp_sym(integ_sum, cfg.integ_limit);
		delta_clamp = clamp_sym(delta_sum, cfg.output_limit);
		integ_next = integ_q;
		delta_next = delta_q;
		if (!gated_s7) begin
			if (!cfg.mode) begin
				if (func_s7 && !ki_on) begin
					integ_next = '0;
				end else begin
					integ_next = integ_clamp[DRIVE_W-1:0];
				end
			end else if (!func_s7) begin
				integ_next = icl_s7[DRIVE_W-1:0];
				delta_next = delta_clamp[DRIVE_W-1:0];
			end
		end
	end

	always_comb begin
		drive_sum = pd_s8 + widen_acc(integ_s8);
		drive_clamp = clamp_sym(drive_sum, cfg.output_limit);
		if (gated_s8) begin
			drive_next = '0;
		end else if (cfg.mode) begin
			drive_next = delta_s8;
		end else begin
			drive_next = drive_clamp[DRIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
			result_valid_q <= 1'b0;
			err_prev_q <= '0;
			err_prev2_q <= '0;
			integ_q <= '0;
			delta_q <= '0;
		end else begin
			if (adv) begin
				stage_vld_q <= {stage_vld_q[STAGES-2:0], cmd_pop};
				result_valid_q <= stage_vld_q[STAGES-1];
			end
			if (cmd_pop && !cmd.gated) begin
				err_prev2_q <= err_prev_q;
				err_prev_q <= cmd.err;
			end
			if (adv && stage_vld_q[STAGES-2]) begin
				integ_q <= integ_next;
				delta_q <= delta_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= cmd.func;
			gated_s1 <= cmd.gated;
			err_s1 <= cmd.err;
			d1_s1 <= diff1;
			d2_s1 <= diff2;
			gyro_s1 <= cmd.gyro_rate;

			func_s2 <= func_s1;
			gated_s2 <= gated_s1;
			prop_s2 <= prop_mul;
			deriv_s2 <= deriv_mul;
			kie_s2 <= kie_mul;

			func_s3 <= func_s2;
			gated_s3 <= gated_s2;
			neg_s3 <= deriv_s2[MUL_W-1];
			y_s3 <= deriv_mag[Y_W-1:0] + Y_W'(DIV_HALF);
			prop_s3 <= prop_s2;
			deriv_s3 <= deriv_s2;
			kie_s3 <= kie_s2;
			icl_s3 <= clamp_sym(widen_mul(kie_s2), cfg.integ_limit);

			func_s4 <= func_s3;
			gated_s4 <= gated_s3;
			neg_s4 <= neg_s3;
			y_s4 <= y_s3;
			lo_s4 <= y_s3[Y_LO_W-1:0] * DIV_RECIP;
			hi_s4 <= y_s3[Y_W-1:Y_LO_W] * DIV_RECIP;
			prop_s4 <= prop_s3;
			deriv_s4 <= deriv_s3;
			kie_s4 <= kie_s3;
			icl_s4 <= icl_s3;

			func_s5 <= func_s4;
			gated_s5 <= gated_s4;
			neg_s5 <= neg_s4;
			y_s5 <= y_s4;
			q_est_s5 <= full_prod[FULL_W-1:DIV_SHIFT];
			prop_s5 <= prop_s4;
			deriv_s5 <= deriv_s4;
			kie_s5 <= kie_s4;
			icl_s5 <= icl_s4;

			func_s6 <= func_s5;
			gated_s6 <= gated_s5;
			prop_s6 <= prop_s5;
			kie_s6 <= kie_s5;
			icl_s6 <= icl_s5;
			dterm_s6 <= dterm;

			func_s7 <= func_s6;
			gated_s7 <= gated_s6;
			kie_s7 <= kie_s6;
			icl_s7 <= icl_s6;
			pd_s7 <= pd_sum;
			inc_s7 <= pd_sum + icl_s6;

			gated_s8 <= gated_s7;
			pd_s8 <= pd_s7;
			integ_s8 <= integ_next;
			delta_s8 <= delta_next;

			result_q.drive <= drive_next;
			result_q.gated <= gated_s8;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

### hdl/pid_position_delta_controller.sv
// Fixed-point PID controller, positional or incremental, taking one request per clock while
// item_stall is low and returning one drive value per request, in order, through a two-entry
// input queue. The sustained rate of one request per cycle while the output is not stalled
// is set by the state stage, where the integrator or the accumulated delta output is added
// and clamped; the gyro term is divided by 100 through a reciprocal multiply split into
// partial products, their sum and a remainder correction. Registers are written through the
// configuration port, which is always ready, and must only change while no request is in
// flight.
module pid_position_delta_controller
	import pidpd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t          cfg_q;
	queue_status_t q_status;
	logic          q_push;
	logic          q_pop;
	cmd_t          push_cmd;
	cmd_t          head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE: begin
					cfg_q.mode <= cfg_data[0];
				end
				REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[GAIN_W-1:0];
				end
				REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[GAIN_W-1:0];
				end
				REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[GAIN_W-1:0];
				end
				REG_OUTPUT_LIMIT: begin
					cfg_q.output_limit <= cfg_data[LIMIT_W-1:0];
				end
				REG_INTEGRAL_LIMIT: begin
					cfg_q.integ_limit <= cfg_data[LIMIT_W-1:0];
				end
				REG_ERROR_CEILING: begin
					cfg_q.error_ceiling <= cfg_data[THRESH_W-1:0];
				end
				REG_DEAD_ZONE: begin
					cfg_q.dead_zone <= cfg_data[THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pidpd_front u_front (
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (q_push),
		.cmd        (push_cmd)
	);

	pidpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.q_status (q_status)
	);

	pidpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.cmd          (head_cmd),
		.cmd_pop      (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_gated_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.gated |-> result.drive == '0)
		else $error("A gated result carries a nonzero drive.");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !q_status.empty)
		else $error("An accepted request did not reach the queue.");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> !q_pop)
		else $error("The queue was drained while the result was stalled.");

endmodule
